/* hw/rtl/kol_pkg.sv */
// Shared types, character codes, token kinds and keyword table of the lexer.
`default_nettype none
package kol_pkg;

	localparam int OFFSET_BITS = 24;
	localparam int WBUF_LEN    = 8;
	localparam int QDEPTH      = 4;
	localparam int NKW         = 27;

	// token kinds
	localparam logic [5:0] K_EOF     = 6'd0;
	localparam logic [5:0] K_NEWLINE = 6'd1;
	localparam logic [5:0] K_NUMBER  = 6'd2;
	localparam logic [5:0] K_IDENT   = 6'd3;
	localparam logic [5:0] K_STRING  = 6'd4;
	localparam logic [5:0] K_KW0     = 6'd5;
	localparam logic [5:0] K_PLUS    = 6'd32;
	localparam logic [5:0] K_PLUSEQ  = 6'd33;
	localparam logic [5:0] K_INC     = 6'd34;
	localparam logic [5:0] K_MINUS   = 6'd35;
	localparam logic [5:0] K_MINUSEQ = 6'd36;
	localparam logic [5:0] K_DEC     = 6'd37;
	localparam logic [5:0] K_SLASH   = 6'd38;
	localparam logic [5:0] K_STAR    = 6'd39;
	localparam logic [5:0] K_ASSIGN  = 6'd40;
	localparam logic [5:0] K_EQEQ    = 6'd41;
	localparam logic [5:0] K_GT      = 6'd42;
	localparam logic [5:0] K_GTEQ    = 6'd43;
	localparam logic [5:0] K_LT      = 6'd44;
	localparam logic [5:0] K_LTEQ    = 6'd45;
	localparam logic [5:0] K_NOTEQ   = 6'd46;
	localparam logic [5:0] K_COLON   = 6'd47;

	// error codes
	localparam logic [2:0] E_NONE    = 3'd0;
	localparam logic [2:0] E_STRCHAR = 3'd1;
	localparam logic [2:0] E_FRAC    = 3'd2;
	localparam logic [2:0] E_BANG    = 3'd3;
	localparam logic [2:0] E_UNKNOWN = 3'd4;
	localparam logic [2:0] E_UNTERM  = 3'd5;

	// characters
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_BSL   = 8'h5C;

	// keyword text, right aligned, first character highest
	localparam logic [63:0] KW_TEXT [NKW] = '{
		"LABEL", "GOTO", "PRINT", "INPUT", "LET", "CAST", "IF", "THEN", "ENDIF",
		"ELIF", "ELSE", "WHILE", "REPEAT", "ENDWHILE", "FOR", "ENDFOR", "OR",
		"AND", "False", "True", "None", "int", "float", "double", "string",
		"bool", "auto"};
	localparam logic [3:0] KW_LEN [NKW] = '{
		4'd5, 4'd4, 4'd5, 4'd5, 4'd3, 4'd4, 4'd2, 4'd4, 4'd5, 4'd4, 4'd4, 4'd5,
		4'd6, 4'd8, 4'd3, 4'd6, 4'd2, 4'd3, 4'd5, 4'd4, 4'd4, 4'd3, 4'd5, 4'd6,
		4'd6, 4'd4, 4'd4};

	typedef struct packed {
		logic [7:0] source_byte;
		logic       end_of_source;
	} src_word_t;

	typedef struct packed {
		logic [5:0]  token_kind;
		logic [23:0] token_start;
		logic [23:0] token_length;
		logic [2:0]  error_code;
		logic        last_result;
	} tok_word_t;

	// all results of one input item
	typedef struct packed {
		logic [1:0]           cnt;
		tok_word_t [2:0]      slot;
	} bundle_t;

	typedef logic [WBUF_LEN-1:0][7:0] wbuf_t;

	// match the buffered word against every keyword in parallel
	function automatic logic [5:0] kw_lookup(input wbuf_t wb, input logic [3:0] len);
		logic [5:0] k;
		logic       hit;
		logic [2:0] pos;
		k = K_IDENT;
		for (int i = NKW - 1; i >= 0; i--) begin
			hit = (KW_LEN[i] == len);
			for (int j = 0; j < WBUF_LEN; j++) begin
				pos = 3'(KW_LEN[i] - 4'd1 - 4'(j));
				if ((4'(j) < KW_LEN[i]) && (wb[j] != KW_TEXT[i][8*pos +: 8]))
					hit = 1'b0;
			end
			if (hit)
				k = K_KW0 + 6'(i);
		end
		return k;
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/kol_front.sv */
// Lexer front end: accepts source words and turns each into a bundle of tokens.
`default_nettype none
module kol_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire kol_pkg::src_word_t src_word,
	output logic                   push,
	output kol_pkg::bundle_t       bundle
);
	import kol_pkg::*;

	localparam logic [3:0] M_IDLE    = 4'd0;
	localparam logic [3:0] M_COMMENT = 4'd1;
	localparam logic [3:0] M_STRING  = 4'd2;
	localparam logic [3:0] M_NUMINT  = 4'd3;
	localparam logic [3:0] M_NUMDOT  = 4'd4;
	localparam logic [3:0] M_NUMFRAC = 4'd5;
	localparam logic [3:0] M_WORD    = 4'd6;
	localparam logic [3:0] M_OPER    = 4'd7;
	localparam logic [3:0] M_DONE    = 4'd8;
	localparam logic [3:0] M_HALT    = 4'd9;

	localparam logic [23:0] LEN_MAX = 24'hFFFFFF;

	logic [3:0]             mode_q, mode_d;
	logic [7:0]             held_q, held_d;
	logic [OFFSET_BITS-1:0] pos_q, pos_d, beg_q, beg_d;
	logic [23:0]            wlen_q, wlen_d;
	wbuf_t                  wbuf_q, wbuf_d;

	tok_word_t  res [3];
	logic [1:0] n;
	logic       disp;
	logic [5:0] wkind;
	logic [7:0] c;
	logic       is_dig, is_alp;

	function automatic tok_word_t mk(input logic [5:0] k, input logic [OFFSET_BITS-1:0] s,
		input logic [23:0] l, input logic [2:0] e);
		tok_word_t t;
		t.token_kind   = k;
		t.token_start  = 24'(s);
		t.token_length = l;
		t.error_code   = e;
		t.last_result  = 1'b0;
		return t;
	endfunction

	function automatic logic [5:0] single_kind(input logic [7:0] h);
		priority case (h)
			CH_PLUS:  return K_PLUS;
			CH_MINUS: return K_MINUS;
			CH_EQ:    return K_ASSIGN;
			CH_GT:    return K_GT;
			default:  return K_LT;
		endcase
	endfunction

	function automatic logic [5:0] eq_kind(input logic [7:0] h);
		priority case (h)
			CH_PLUS:  return K_PLUSEQ;
			CH_MINUS: return K_MINUSEQ;
			CH_EQ:    return K_EQEQ;
			CH_GT:    return K_GTEQ;
			CH_LT:    return K_LTEQ;
			default:  return K_NOTEQ;
		endcase
	endfunction

	assign c      = src_word.source_byte;
	assign is_dig = (c >= 8'h30) && (c <= 8'h39);
	assign is_alp = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
	assign wkind  = (wlen_q > 24'(WBUF_LEN)) ? K_IDENT : kw_lookup(wbuf_q, wlen_q[3:0]);

	// classify the word and collect its tokens
	always_comb begin
		mode_d = mode_q;
		held_d = held_q;
		pos_d  = pos_q;
		beg_d  = beg_q;
		wlen_d = wlen_q;
		wbuf_d = wbuf_q;
		res    = '{default: '0};
		n      = 2'd0;
		disp   = 1'b0;
		if (mode_q == M_HALT) begin
		end else if (src_word.end_of_source || mode_q == M_DONE) begin
			if (mode_q == M_DONE) begin
				res[n] = mk(K_EOF, pos_q, 24'd0, E_NONE); n = n + 2'd1;
			end else begin
				priority case (mode_q)
					M_STRING: begin
						res[n] = mk(K_EOF, pos_q, 24'd0, E_UNTERM); n = n + 2'd1;
						mode_d = M_HALT;
					end
					M_NUMDOT: begin
						res[n] = mk(K_EOF, pos_q, 24'd0, E_FRAC); n = n + 2'd1;
						mode_d = M_HALT;
					end
					M_NUMINT, M_NUMFRAC: begin
						res[n] = mk(K_NUMBER, beg_q, wlen_q, E_NONE); n = n + 2'd1;
					end
					M_WORD: begin
						res[n] = mk(wkind, beg_q, wlen_q, E_NONE); n = n + 2'd1;
					end
					M_OPER: begin
						if (held_q == CH_BANG) begin
							res[n] = mk(K_EOF, beg_q, 24'd0, E_BANG); n = n + 2'd1;
							mode_d = M_HALT;
						end else begin
							res[n] = mk(single_kind(held_q), beg_q, 24'd1, E_NONE);
							n = n + 2'd1;
						end
					end
					default: begin
					end
				endcase
				if (mode_d != M_HALT) begin
					res[n] = mk(K_NEWLINE, pos_q, 24'd0, E_NONE); n = n + 2'd1;
					res[n] = mk(K_EOF, pos_q, 24'd0, E_NONE); n = n + 2'd1;
					mode_d = M_DONE;
				end
			end
		end else begin
			pos_d = pos_q + 1'b1;
			priority case (mode_q)
				M_COMMENT: disp = (c == CH_LF);
				M_STRING: begin
					if (c == CH_QUOTE) begin
						res[n] = mk(K_STRING, beg_q, wlen_q, E_NONE); n = n + 2'd1;
						mode_d = M_IDLE;
					end else if (c == CH_CR || c == CH_LF || c == CH_TAB || c == CH_BSL ||
						c == CH_PCT) begin
						res[n] = mk(K_EOF, pos_q, 24'd0, E_STRCHAR); n = n + 2'd1;
						mode_d = M_HALT;
					end else if (wlen_q != LEN_MAX) begin
						wlen_d = wlen_q + 24'd1;
					end
				end
				M_NUMINT, M_NUMFRAC: begin
					if (is_dig || (mode_q == M_NUMINT && c == CH_DOT)) begin
						if (wlen_q != LEN_MAX)
							wlen_d = wlen_q + 24'd1;
						if (!is_dig)
							mode_d = M_NUMDOT;
					end else begin
						res[n] = mk(K_NUMBER, beg_q, wlen_q, E_NONE); n = n + 2'd1;
						disp = 1'b1;
					end
				end
				M_NUMDOT: begin
					if (is_dig) begin
						if (wlen_q != LEN_MAX)
							wlen_d = wlen_q + 24'd1;
						mode_d = M_NUMFRAC;
					end else begin
						res[n] = mk(K_EOF, pos_q, 24'd0, E_FRAC); n = n + 2'd1;
						mode_d = M_HALT;
					end
				end
				M_WORD: begin
					if (is_dig || is_alp) begin
						if (wlen_q < 24'(WBUF_LEN))
							wbuf_d[wlen_q[$clog2(WBUF_LEN)-1:0]] = c;
						if (wlen_q != LEN_MAX)
							wlen_d = wlen_q + 24'd1;
					end else begin
						res[n] = mk(wkind, beg_q, wlen_q, E_NONE); n = n + 2'd1;
						disp = 1'b1;
					end
				end
				M_OPER: begin
					if (c == CH_EQ) begin
						res[n] = mk(eq_kind(held_q), beg_q, 24'd2, E_NONE); n = n + 2'd1;
						mode_d = M_IDLE;
					end else if (c == held_q && (c == CH_PLUS || c == CH_MINUS)) begin
						res[n] = mk((c == CH_PLUS) ? K_INC : K_DEC, beg_q, 24'd2, E_NONE);
						n = n + 2'd1;
						mode_d = M_IDLE;
					end else if (held_q == CH_BANG) begin
						res[n] = mk(K_EOF, beg_q, 24'd0, E_BANG); n = n + 2'd1;
						mode_d = M_HALT;
					end else begin
						res[n] = mk(single_kind(held_q), beg_q, 24'd1, E_NONE); n = n + 2'd1;
						disp = 1'b1;
					end
				end
				default: disp = 1'b1;
			endcase
			// start a new token from this byte
			if (disp) begin
				mode_d = M_IDLE;
				priority case (c)
					CH_SPACE, CH_TAB, CH_CR: begin
					end
					CH_HASH: mode_d = M_COMMENT;
					CH_LF: begin
						res[n] = mk(K_NEWLINE, pos_q, 24'd1, E_NONE); n = n + 2'd1;
					end
					CH_SLASH: begin
						res[n] = mk(K_SLASH, pos_q, 24'd1, E_NONE); n = n + 2'd1;
					end
					CH_STAR: begin
						res[n] = mk(K_STAR, pos_q, 24'd1, E_NONE); n = n + 2'd1;
					end
					CH_COLON: begin
						res[n] = mk(K_COLON, pos_q, 24'd1, E_NONE); n = n + 2'd1;
					end
					CH_PLUS, CH_MINUS, CH_EQ, CH_GT, CH_LT, CH_BANG: begin
						mode_d = M_OPER;
						held_d = c;
						beg_d  = pos_q;
					end
					CH_QUOTE: begin
						mode_d = M_STRING;
						beg_d  = pos_q + 1'b1;
						wlen_d = 24'd0;
					end
					CH_NUL: begin
						res[n] = mk(K_EOF, pos_q, 24'd0, E_NONE); n = n + 2'd1;
					end
					default: begin
						if (is_dig) begin
							mode_d = M_NUMINT;
							beg_d  = pos_q;
							wlen_d = 24'd1;
						end else if (is_alp) begin
							mode_d    = M_WORD;
							beg_d     = pos_q;
							wbuf_d[0] = c;
							wlen_d    = 24'd1;
						end else begin
							res[n] = mk(K_EOF, pos_q, 24'd0, E_UNKNOWN); n = n + 2'd1;
							mode_d = M_HALT;
						end
					end
				endcase
			end
		end
	end

	assign push              = accept && (n != 2'd0);
	assign bundle.cnt        = n;
	assign bundle.slot[0]    = res[0];
	assign bundle.slot[1]    = res[1];
	assign bundle.slot[2]    = res[2];

	// advance lexer state on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			held_q <= '0;
			pos_q  <= '0;
			beg_q  <= '0;
			wlen_q <= '0;
		end else if (accept) begin
			mode_q <= mode_d;
			held_q <= held_d;
			pos_q  <= pos_d;
			beg_q  <= beg_d;
			wlen_q <= wlen_d;
		end
	end

	// hold word text; unread until written
	always_ff @(posedge clk) begin
		if (accept)
			wbuf_q <= wbuf_d;
	end

endmodule
`default_nettype wire

/* hw/rtl/kol_queue.sv */
// Short bundle queue between lexer front end and token output stage.
`default_nettype none
module kol_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire kol_pkg::bundle_t  wdata,
	input  wire logic              pop,
	output logic                   nonempty,
	output logic                   full,
	output kol_pkg::bundle_t       rdata
);
	import kol_pkg::*;

	localparam int AW = $clog2(QDEPTH);

	bundle_t     mem_q [QDEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   count_q;

	assign nonempty = (count_q != '0);
	assign full     = (count_q == (AW+1)'(QDEPTH));
	assign rdata    = mem_q[rd_q];

	// store pushed bundles
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= wdata;
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("bundle queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> nonempty)
		else $error("bundle queue underflow");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("bundle queue count mismatch");
	a_nonempty_bundle: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (wdata.cnt != 2'd0))
		else $error("empty bundle pushed");
`endif

endmodule
`default_nettype wire

/* hw/rtl/kol_back.sv */
// Token output stage: unpacks bundles and drives one token word per cycle unless stalled.
`default_nettype none
module kol_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_nonempty,
	input  wire kol_pkg::bundle_t  q_data,
	output logic                   pop,
	output logic                   tok_valid,
	input  wire logic              tok_stall,
	output kol_pkg::tok_word_t     tok_word
);
	import kol_pkg::*;

	bundle_t    cur_q;
	logic [1:0] idx_q;
	logic       have_q;
	logic       out_free, emit, last_one;
	tok_word_t  nxt;

	assign out_free = !tok_valid || !tok_stall;
	assign emit     = out_free && have_q;
	assign last_one = (idx_q == cur_q.cnt - 2'd1);
	assign pop      = q_nonempty && (!have_q || (emit && last_one));

	always_comb begin
		unique case (idx_q)
			2'd0:    nxt = cur_q.slot[0];
			2'd1:    nxt = cur_q.slot[1];
			default: nxt = cur_q.slot[2];
		endcase
		nxt.last_result = last_one;
	end

	// load bundles and step through their tokens
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q    <= 1'b0;
			idx_q     <= '0;
			tok_valid <= 1'b0;
		end else begin
			if (pop) begin
				have_q <= 1'b1;
				idx_q  <= '0;
			end else if (emit && last_one) begin
				have_q <= 1'b0;
			end else if (emit) begin
				idx_q <= idx_q + 2'd1;
			end
			if (out_free)
				tok_valid <= have_q;
		end
	end

	// hold bundle and output payload
	always_ff @(posedge clk) begin
		if (pop)
			cur_q <= q_data;
		if (emit)
			tok_word <= nxt;
	end

endmodule
`default_nettype wire

/* hw/rtl/keyword_operator_lexer.sv */
// Top level of the keyword and operator lexer.
`default_nettype none
// Takes one source byte (or an end-of-source marker) per cycle while src_stall
// is low and delivers tokens with kind, start offset and length; the last token
// caused by a byte carries last_result. The front end classifies one byte per
// cycle, so bytes flow at one per cycle while tokens are taken. Tokens leave
// through an output register, one per cycle while tok_stall is low; a byte that
// ends one token and starts another, or the end marker (up to three tokens),
// yields more than one token, and a four-entry queue between front end and
// output absorbs these bursts. src_stall rises only when that queue is full.
// After an error the lexer gives no further tokens until reset.
module keyword_operator_lexer (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              src_valid,
	output logic                   src_stall,
	input  wire kol_pkg::src_word_t src_word,
	output logic                   tok_valid,
	input  wire logic              tok_stall,
	output kol_pkg::tok_word_t     tok_word
);
	import kol_pkg::*;

	logic    accept, push, pop, q_nonempty, q_full;
	bundle_t f_bundle, q_bundle;

	assign src_stall = q_full;
	assign accept    = src_valid && !src_stall;

	kol_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.src_word (src_word),
		.push     (push),
		.bundle   (f_bundle)
	);

	kol_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wdata    (f_bundle),
		.pop      (pop),
		.nonempty (q_nonempty),
		.full     (q_full),
		.rdata    (q_bundle)
	);

	kol_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_data     (q_bundle),
		.pop        (pop),
		.tok_valid  (tok_valid),
		.tok_stall  (tok_stall),
		.tok_word   (tok_word)
	);

endmodule
`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for the keyword and operator lexer.
module tb_top;
	import kol_pkg::*;

	localparam int LIMIT = 400000;

	typedef enum logic [3:0] {
		LX_IDLE, LX_COMMENT, LX_STRING, LX_NUMINT, LX_NUMDOT, LX_NUMFRAC,
		LX_WORD, LX_OPER, LX_DONE, LX_HALT
	} lex_mode_t;

	logic       clk;
	logic       arst_n;
	logic       src_valid;
	logic       src_stall;
	src_word_t  src_word;
	logic       tok_valid;
	logic       tok_stall;
	tok_word_t  tok_word;

	keyword_operator_lexer u_top (
		.clk(clk), .arst_n(arst_n),
		.src_valid(src_valid), .src_stall(src_stall), .src_word(src_word),
		.tok_valid(tok_valid), .tok_stall(tok_stall), .tok_word(tok_word)
	);

	// lexer shadow state
	lex_mode_t   mode;
	logic [7:0]  held;
	logic [23:0] pos;
	logic [23:0] tbeg;
	logic [7:0]  wbuf [8];
	logic [23:0] wlen;

	src_word_t  byte_queue [$];
	tok_word_t  token_queue [$];
	tok_word_t  step_toks [$];
	int         errors;
	int         cycles;
	int         hold_off;
	int         gap;
	bit         stim_done;

	function automatic bit is_dig(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_let(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	// queue one token of the current byte
	task automatic push_tok(logic [5:0] k, logic [23:0] s, logic [23:0] l, logic [2:0] e);
		tok_word_t t;
		t.token_kind = k;
		t.token_start = s;
		t.token_length = l;
		t.error_code = e;
		t.last_result = 1'b0;
		step_toks.push_back(t);
	endtask

	task automatic halt_with(logic [2:0] e, logic [23:0] s);
		push_tok(K_EOF, s, 24'd0, e);
		mode = LX_HALT;
	endtask

	function automatic logic [5:0] word_token();
		string kw [27] = '{"LABEL", "GOTO", "PRINT", "INPUT", "LET", "CAST", "IF",
			"THEN", "ENDIF", "ELIF", "ELSE", "WHILE", "REPEAT", "ENDWHILE", "FOR",
			"ENDFOR", "OR", "AND", "False", "True", "None", "int", "float",
			"double", "string", "bool", "auto"};
		bit hit;
		if (wlen > 8)
			return K_IDENT;
		for (int i = 0; i < 27; i++) begin
			hit = (kw[i].len() == wlen);
			for (int j = 0; j < kw[i].len() && hit; j++)
				if (wbuf[j] != kw[i][j])
					hit = 0;
			if (hit)
				return K_KW0 + 6'(i);
		end
		return K_IDENT;
	endfunction

	function automatic logic [5:0] single_op(logic [7:0] h);
		case (h)
			CH_PLUS:  return K_PLUS;
			CH_MINUS: return K_MINUS;
			CH_EQ:    return K_ASSIGN;
			CH_GT:    return K_GT;
			default:  return K_LT;
		endcase
	endfunction

	function automatic logic [5:0] eq_op(logic [7:0] h);
		case (h)
			CH_PLUS:  return K_PLUSEQ;
			CH_MINUS: return K_MINUSEQ;
			CH_EQ:    return K_EQEQ;
			CH_GT:    return K_GTEQ;
			CH_LT:    return K_LTEQ;
			default:  return K_NOTEQ;
		endcase
	endfunction

	task automatic grow_len();
		if (wlen != 24'hFFFFFF)
			wlen++;
	endtask

	// handle a byte with nothing pending
	task automatic start_token(logic [7:0] c, logic [23:0] p);
		mode = LX_IDLE;
		case (c)
			CH_SPACE, CH_TAB, CH_CR: ;
			CH_HASH:  mode = LX_COMMENT;
			CH_LF:    push_tok(K_NEWLINE, p, 24'd1, E_NONE);
			CH_SLASH: push_tok(K_SLASH, p, 24'd1, E_NONE);
			CH_STAR:  push_tok(K_STAR, p, 24'd1, E_NONE);
			CH_COLON: push_tok(K_COLON, p, 24'd1, E_NONE);
			CH_PLUS, CH_MINUS, CH_EQ, CH_GT, CH_LT, CH_BANG: begin
				mode = LX_OPER;
				held = c;
				tbeg = p;
			end
			CH_QUOTE: begin
				mode = LX_STRING;
				tbeg = p + 24'd1;
				wlen = 0;
			end
			CH_NUL: push_tok(K_EOF, p, 24'd0, E_NONE);
			default: begin
				if (is_dig(c)) begin
					mode = LX_NUMINT;
					tbeg = p;
					wlen = 1;
				end else if (is_let(c)) begin
					mode = LX_WORD;
					tbeg = p;
					wbuf[0] = c;
					wlen = 1;
				end else begin
					halt_with(E_UNKNOWN, p);
				end
			end
		endcase
	endtask

	// predict the tokens of one accepted word
	task automatic predict_tokens(src_word_t w);
		logic [7:0]  c;
		logic [23:0] p;
		c = w.source_byte;
		p = pos;
		step_toks.delete();
		if (mode == LX_HALT)
			return;
		if (w.end_of_source || mode == LX_DONE) begin
			case (mode)
				LX_DONE: push_tok(K_EOF, p, 24'd0, E_NONE);
				LX_STRING: halt_with(E_UNTERM, p);
				LX_NUMDOT: halt_with(E_FRAC, p);
				LX_NUMINT, LX_NUMFRAC: push_tok(K_NUMBER, tbeg, wlen, E_NONE);
				LX_WORD: push_tok(word_token(), tbeg, wlen, E_NONE);
				LX_OPER: begin
					if (held == CH_BANG)
						halt_with(E_BANG, tbeg);
					else
						push_tok(single_op(held), tbeg, 24'd1, E_NONE);
				end
				default: ;
			endcase
			if (mode != LX_HALT && mode != LX_DONE) begin
				push_tok(K_NEWLINE, p, 24'd0, E_NONE);
				push_tok(K_EOF, p, 24'd0, E_NONE);
				mode = LX_DONE;
			end
		end else begin
			pos = p + 24'd1;
			case (mode)
				LX_COMMENT: if (c == CH_LF) start_token(c, p);
				LX_STRING: begin
					if (c == CH_QUOTE) begin
						push_tok(K_STRING, tbeg, wlen, E_NONE);
						mode = LX_IDLE;
					end else if (c == CH_CR || c == CH_LF || c == CH_TAB ||
							c == CH_BSL || c == CH_PCT) begin
						halt_with(E_STRCHAR, p);
					end else begin
						grow_len();
					end
				end
				LX_NUMINT: begin
					if (is_dig(c)) begin
						grow_len();
					end else if (c == CH_DOT) begin
						grow_len();
						mode = LX_NUMDOT;
					end else begin
						push_tok(K_NUMBER, tbeg, wlen, E_NONE);
						start_token(c, p);
					end
				end
				LX_NUMDOT: begin
					if (is_dig(c)) begin
						grow_len();
						mode = LX_NUMFRAC;
					end else begin
						halt_with(E_FRAC, p);
					end
				end
				LX_NUMFRAC: begin
					if (is_dig(c)) begin
						grow_len();
					end else begin
						push_tok(K_NUMBER, tbeg, wlen, E_NONE);
						start_token(c, p);
					end
				end
				LX_WORD: begin
					if (is_dig(c) || is_let(c)) begin
						if (wlen < 8)
							wbuf[wlen[2:0]] = c;
						grow_len();
					end else begin
						push_tok(word_token(), tbeg, wlen, E_NONE);
						start_token(c, p);
					end
				end
				LX_OPER: begin
					if (c == CH_EQ) begin
						push_tok(eq_op(held), tbeg, 24'd2, E_NONE);
						mode = LX_IDLE;
					end else if (c == held && (held == CH_PLUS || held == CH_MINUS)) begin
						push_tok(held == CH_PLUS ? K_INC : K_DEC, tbeg, 24'd2, E_NONE);
						mode = LX_IDLE;
					end else if (held == CH_BANG) begin
						halt_with(E_BANG, tbeg);
					end else begin
						push_tok(single_op(held), tbeg, 24'd1, E_NONE);
						start_token(c, p);
					end
				end
				default: start_token(c, p);
			endcase
		end
		if (step_toks.size() > 0)
			step_toks[step_toks.size() - 1].last_result = 1'b1;
		foreach (step_toks[i])
			token_queue.push_back(step_toks[i]);
	endtask

	// stimulus helpers
	task automatic add_byte(logic [7:0] c);
		src_word_t w;
		w.source_byte = c;
		w.end_of_source = 1'b0;
		byte_queue.push_back(w);
	endtask

	task automatic add_text(string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endtask

	task automatic add_end();
		src_word_t w;
		w.source_byte = 8'($urandom);
		w.end_of_source = 1'b1;
		byte_queue.push_back(w);
	endtask

	function automatic string pick_fragment();
		string frag [] = '{"LABEL", "GOTO", "PRINT", "INPUT", "LET", "CAST", "IF",
			"THEN", "ENDIF", "ELIF", "ELSE", "WHILE", "REPEAT", "ENDWHILE", "FOR",
			"ENDFOR", "OR", "AND", "False", "True", "None", "int", "float",
			"double", "string", "bool", "auto", "x", "ab9", "ENDWHILEZ", "autos",
			"42", "3.14", "7.", "0", "\"hi there\"", "\"\"", "+", "+=", "++", "-",
			"-=", "--", "=", "==", "<", "<=", ">", ">=", "!=", "/", "*", ":",
			" ", "\t", "\r", "\n", "#note\n", "  "};
		return frag[$urandom_range(0, frag.size() - 1)];
	endfunction

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// reset and stimulus
	initial begin
		arst_n = 1'b0;
		stim_done = 1'b0;
		// directed: every operator, keyword matching, numbers, strings, comments
		add_text("LET x1 = 3.25 + 17\n");
		add_text("a+=b++c-=d--e==f>=g<=h!=i/j*k:l<m>n-o\t\r#skip \x80\n");
		add_text("\"str ok\" ENDWHILE auto True ENDWHILEX\x00 7");
		add_end();
		add_byte(8'hFF);
		add_end();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	// build random source text after reset, until at least 100 words are queued
	initial begin
		int n;
		int r;
		@(posedge arst_n);
		n = 0;
		while (n < 100) begin
			r = $urandom_range(0, 99);
			if (r < 85) begin
				string s;
				s = pick_fragment();
				add_text(s);
				n += s.len();
			end else if (r < 93) begin
				add_byte(8'($urandom));
				n++;
			end else begin
				add_end();
				n++;
			end
			if (byte_queue.size() > 40)
				@(posedge clk);
		end
		// last setting: an extreme byte and the end marker
		add_byte(8'hFF);
		add_end();
		stim_done = 1'b1;
	end

	// drive source words
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_valid <= 1'b0;
			src_word <= '0;
			gap <= 0;
		end else if (!src_valid || !src_stall) begin
			if (src_valid)
				predict_tokens(src_word);
			if (gap > 0) begin
				gap <= gap - 1;
				src_valid <= 1'b0;
			end else if (byte_queue.size() > 0 && $urandom_range(0, 9) > 2) begin
				src_valid <= 1'b1;
				src_word <= byte_queue.pop_front();
			end else if ($urandom_range(0, 30) == 0) begin
				src_valid <= 1'b0;
				src_word <= '0;
				gap <= $urandom_range(10, 40);
			end else begin
				src_valid <= 1'b0;
			end
		end
	end

	// receiver stall with an occasional long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_stall <= 1'b0;
			hold_off <= 300;
		end else if (cycles == 200 || cycles == 3000) begin
			hold_off <= 80;
			tok_stall <= 1'b1;
		end else if (hold_off > 0 && hold_off < 300) begin
			hold_off <= hold_off - 1;
			tok_stall <= hold_off != 1;
		end else begin
			tok_stall <= ($urandom_range(0, 99) < 20) ||
				((cycles / 500) % 7 == 3 && $urandom_range(0, 3) != 0);
		end
	end

	// check tokens against expectations
	always @(posedge clk) begin
		if (arst_n && tok_valid && !tok_stall) begin
			if (token_queue.size() == 0) begin
				$error("unexpected token kind %0d", tok_word.token_kind);
				errors++;
			end else begin
				tok_word_t e;
				e = token_queue.pop_front();
				if (e.token_kind !== tok_word.token_kind) begin
					$error("token_kind exp %0d got %0d", e.token_kind, tok_word.token_kind);
					errors++;
				end
				if (e.token_start !== tok_word.token_start) begin
					$error("token_start exp %0d got %0d", e.token_start, tok_word.token_start);
					errors++;
				end
				if (e.token_length !== tok_word.token_length) begin
					$error("token_length exp %0d got %0d", e.token_length,
						tok_word.token_length);
					errors++;
				end
				if (e.error_code !== tok_word.error_code) begin
					$error("error_code exp %0d got %0d", e.error_code, tok_word.error_code);
					errors++;
				end
				if (e.last_result !== tok_word.last_result) begin
					$error("last_result exp %0d got %0d", e.last_result, tok_word.last_result);
					errors++;
				end
			end
		end
	end

	// wrap up and watchdog
	initial begin
		errors = 0;
		cycles = 0;
		mode = LX_IDLE;
		held = 0;
		pos = 0;
		tbeg = 0;
		wlen = 0;
		foreach (wbuf[i])
			wbuf[i] = 0;
		@(posedge arst_n);
		while (!(stim_done && byte_queue.size() == 0 && !src_valid &&
				token_queue.size() == 0) && cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		if (cycles >= LIMIT) begin
			$display("Some tests failed");
		end else begin
			repeat (20) @(posedge clk);
			if (errors == 0 && token_queue.size() == 0)
				$display("All tests passed");
			else
				$display("Some tests failed");
		end
		$finish;
	end

endmodule
